// ===== rtl/iau_pkg.sv =====
// Shared types, widths and codes for the interval arithmetic unit.
// No dependencies; every other file imports this package.
package iau_pkg;

  localparam int VALUE_WIDTH = 48;
  localparam int FRAC_BITS   = 16;

  // magnitude of a finite bound, and the split for partial products
  localparam int MAG_W      = VALUE_WIDTH - 1;
  localparam int SPLIT_W    = (MAG_W + 1) / 2;
  localparam int SPLIT_HI_W = MAG_W - SPLIT_W;
  localparam int PROD_W     = 2 * MAG_W;

  // reciprocal: 2^(2*FRAC_BITS) / m, one quotient bit per stage
  localparam int QUO_W       = 2 * FRAC_BITS + 1;
  localparam int REM_W       = MAG_W + 1;
  localparam int CMP_W       = (QUO_W > VALUE_WIDTH) ? QUO_W : VALUE_WIDTH;
  localparam int RECIP_DEPTH = QUO_W + 2;

  // control line: input stage, reciprocal, three multiply stages, min/max pair
  localparam int CTL_DEPTH = RECIP_DEPTH + 5;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam logic [VALUE_WIDTH-1:0] MAXMAG = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t PINF = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t NINF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t ZERO = '0;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_SUB   = 3'd1;
  localparam logic [2:0] CMD_MUL   = 3'd2;
  localparam logic [2:0] CMD_DIV   = 3'd3;
  localparam logic [2:0] CMD_HULL  = 3'd4;
  localparam logic [2:0] CMD_ISECT = 3'd5;
  localparam logic [2:0] CMD_WIDEN = 3'd6;
  localparam logic [2:0] CMD_NARROW = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZSPAN = 2'd2;
  localparam logic [1:0] ST_UNDEF = 2'd3;

  // one item as it travels down the pipeline; e_* is the non-multiply result
  typedef struct packed {
    logic [2:0] cmd;
    value_t     a_lo;
    value_t     a_hi;
    logic       a_def;
    value_t     b_lo;
    value_t     b_hi;
    logic       b_def;
    value_t     e_lo;
    value_t     e_hi;
    logic       e_def;
    logic [1:0] e_st;
    logic       below;
    logic       above;
    logic       equal;
  } item_t;

endpackage

// ===== rtl/iau_addlat.sv =====
// Add, subtract, lattice commands, operand checks and order flags.
// Purely combinational; depends on iau_pkg. Registered by the top level.
module iau_addlat import iau_pkg::*; (
  input  item_t item_in,
  output item_t item_out
);

  localparam logic signed [VALUE_WIDTH:0] PINF_X = {2'b00, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH:0] NINF_X = {2'b11, {(VALUE_WIDTH-1){1'b0}}};

  // negate with swapped infinities; the most negative finite code goes to plus infinity
  function automatic value_t neg_bound(input value_t v);
    value_t r;
    begin
      if (v == NINF || v == NINF + value_t'(1)) r = PINF;
      else if (v == PINF) r = NINF;
      else r = -v;
      return r;
    end
  endfunction

  // saturating sum; opposite infinities are caught separately
  function automatic value_t sat_add(input value_t x, input value_t y);
    logic signed [VALUE_WIDTH:0] s;
    value_t r;
    begin
      s = {x[VALUE_WIDTH-1], x} + {y[VALUE_WIDTH-1], y};
      if (x == PINF || y == PINF) r = PINF;
      else if (x == NINF || y == NINF) r = NINF;
      else if (s >= PINF_X) r = PINF;
      else if (s <= NINF_X) r = NINF;
      else r = s[VALUE_WIDTH-1:0];
      return r;
    end
  endfunction

  function automatic logic opp_inf(input value_t x, input value_t y);
    return (x == NINF && y == PINF) || (x == PINF && y == NINF);
  endfunction

  value_t     al, ah, bl, bh;
  value_t     nl, nh, tl, th, lo, hi;
  logic [1:0] st;
  logic       def;

  assign al = item_in.a_lo;
  assign ah = item_in.a_hi;
  assign bl = item_in.b_lo;
  assign bh = item_in.b_hi;
  assign nl = neg_bound(bh);
  assign nh = neg_bound(bl);

  // pick the second operand of the sum, ordered for subtract
  always_comb begin
    if (item_in.cmd == CMD_SUB) begin
      tl = (nh < nl) ? nh : nl;
      th = (nh < nl) ? nl : nh;
    end else begin
      tl = bl;
      th = bh;
    end
  end

  // result of every command but multiply and divide, and their checks
  always_comb begin
    lo  = ZERO;
    hi  = ZERO;
    def = 1'b1;
    st  = ST_OK;
    if (item_in.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV}) begin
      if (!item_in.a_def || !item_in.b_def) begin
        st = ST_UNDEF;
      end else begin
        case (item_in.cmd)
          CMD_ADD, CMD_SUB: begin
            if (opp_inf(al, tl) || opp_inf(ah, th)) begin
              st = ST_UNDEF;
            end else begin
              lo = sat_add(al, tl);
              hi = sat_add(ah, th);
            end
          end
          CMD_DIV: begin
            if (!(bl > ZERO || bh < ZERO)) st = ST_ZSPAN;
          end
          default: st = ST_OK;
        endcase
      end
    end else if (!item_in.b_def) begin
      lo  = al;
      hi  = ah;
      def = item_in.a_def;
      if (!item_in.a_def) st = ST_UNDEF;
    end else if (!item_in.a_def) begin
      lo = bl;
      hi = bh;
    end else begin
      case (item_in.cmd)
        CMD_HULL: begin
          lo = (al < bl) ? al : bl;
          hi = (ah > bh) ? ah : bh;
          if (lo > hi) st = ST_EMPTY;
        end
        CMD_ISECT: begin
          lo = (al > bl) ? al : bl;
          hi = (ah < bh) ? ah : bh;
          if (lo > hi) st = ST_EMPTY;
        end
        CMD_WIDEN: begin
          lo = (bl < al) ? NINF : al;
          hi = (bh > ah) ? PINF : ah;
        end
        default: begin
          lo = (al == NINF) ? bl : ((al < bl) ? al : bl);
          hi = (ah == PINF) ? bh : ((ah > bh) ? ah : bh);
        end
      endcase
    end
    // empty, zero-span and undefined add/sub/mul/div results carry zero bounds
    if (st == ST_EMPTY || st == ST_ZSPAN ||
        (st == ST_UNDEF && item_in.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV})) begin
      lo  = ZERO;
      hi  = ZERO;
      def = 1'b0;
    end
    if (st == ST_UNDEF) def = 1'b0;
  end

  always_comb begin
    item_out       = item_in;
    item_out.e_lo  = lo;
    item_out.e_hi  = hi;
    item_out.e_def = def;
    item_out.e_st  = st;
    item_out.below = ah < bl;
    item_out.above = bh < al;
    item_out.equal = (al == bl) && (ah == bh);
  end

endmodule

// ===== rtl/iau_recip.sv =====
// Pipelined reciprocal 2^(2*FRAC_BITS)/|x| with sign, infinity and saturation.
// One restoring quotient bit per stage; depends on iau_pkg.
module iau_recip import iau_pkg::*; (
  input  logic   clk,
  input  logic   adv,
  input  value_t value,
  output value_t recip
);

  logic [MAG_W-1:0] m_s    [0:QUO_W];
  logic [REM_W-1:0] rem_s  [0:QUO_W];
  logic [QUO_W-1:0] quo_s  [0:QUO_W];
  logic             inf_s  [0:QUO_W];
  logic             zero_s [0:QUO_W];
  logic             neg_s  [0:QUO_W];
  logic [VALUE_WIDTH-1:0] mag;
  logic [CMP_W-1:0]       qext;
  value_t                 qval;

  assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  // capture the magnitude and special cases
  always_ff @(posedge clk) begin
    if (adv) begin
      m_s[0]    <= mag[MAG_W-1:0];
      rem_s[0]  <= '0;
      quo_s[0]  <= '0;
      inf_s[0]  <= (value == PINF) || (value == NINF);
      zero_s[0] <= (value == ZERO);
      neg_s[0]  <= value[VALUE_WIDTH-1];
    end
  end

  // one compare and subtract per stage; the dividend has only its top bit set
  for (genvar i = 1; i <= QUO_W; i++) begin : g_step
    localparam logic NUM_BIT = (i == 1) ? 1'b1 : 1'b0;
    logic [REM_W-1:0] shifted;
    logic             ge;
    assign shifted = {rem_s[i-1][REM_W-2:0], NUM_BIT};
    assign ge      = shifted >= {1'b0, m_s[i-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        m_s[i]    <= m_s[i-1];
        rem_s[i]  <= ge ? (shifted - {1'b0, m_s[i-1]}) : shifted;
        quo_s[i]  <= quo_s[i-1] | (QUO_W'(ge) << (QUO_W - i));
        inf_s[i]  <= inf_s[i-1];
        zero_s[i] <= zero_s[i-1];
        neg_s[i]  <= neg_s[i-1];
      end
    end
  end

  assign qext = CMP_W'(quo_s[QUO_W]);
  assign qval = qext[VALUE_WIDTH-1:0];

  // apply sign and saturate; infinity gives zero, zero gives plus infinity
  always_ff @(posedge clk) begin
    if (adv) begin
      if (inf_s[QUO_W]) recip <= ZERO;
      else if (zero_s[QUO_W]) recip <= PINF;
      else if (qext >= CMP_W'(MAXMAG)) recip <= neg_s[QUO_W] ? NINF : PINF;
      else recip <= neg_s[QUO_W] ? -qval : qval;
    end
  end

endmodule

// ===== rtl/iau_mul.sv =====
// Three-stage fixed-point bound multiplier: partial products, sum, scale.
// Zero wins over infinity; overflow saturates. Depends on iau_pkg.
module iau_mul import iau_pkg::*; (
  input  logic   clk,
  input  logic   adv,
  input  value_t x,
  input  value_t y,
  output value_t prod
);

  logic [VALUE_WIDTH-1:0] ax, ay;
  logic [SPLIT_W-1:0]     xl, yl;
  logic [SPLIT_HI_W-1:0]  xh, yh;

  logic                          zr1, inf1, neg1, zr2, inf2, neg2;
  logic [2*SPLIT_W-1:0]          p00;
  logic [SPLIT_W+SPLIT_HI_W-1:0] p01, p10;
  logic [2*SPLIT_HI_W-1:0]       p11;
  logic [PROD_W-1:0]             full, q;
  value_t                        qval;

  assign ax = x[VALUE_WIDTH-1] ? (~x + 1'b1) : x;
  assign ay = y[VALUE_WIDTH-1] ? (~y + 1'b1) : y;
  assign xl = ax[SPLIT_W-1:0];
  assign xh = ax[MAG_W-1:SPLIT_W];
  assign yl = ay[SPLIT_W-1:0];
  assign yh = ay[MAG_W-1:SPLIT_W];

  // partial products of the magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      zr1  <= (x == ZERO) || (y == ZERO);
      inf1 <= (x == PINF) || (x == NINF) || (y == PINF) || (y == NINF);
      neg1 <= x[VALUE_WIDTH-1] ^ y[VALUE_WIDTH-1];
      p00  <= xl * yl;
      p01  <= xl * yh;
      p10  <= xh * yl;
      p11  <= xh * yh;
    end
  end

  // combine into the full product
  always_ff @(posedge clk) begin
    if (adv) begin
      zr2  <= zr1;
      inf2 <= inf1;
      neg2 <= neg1;
      full <= (PROD_W'(p11) << (2 * SPLIT_W)) +
              ((PROD_W'(p01) + PROD_W'(p10)) << SPLIT_W) + PROD_W'(p00);
    end
  end

  assign q    = full >> FRAC_BITS;
  assign qval = q[VALUE_WIDTH-1:0];

  // scale, sign and saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      if (zr2) prod <= ZERO;
      else if (inf2 || q >= PROD_W'(MAXMAG)) prod <= neg2 ? NINF : PINF;
      else prod <= neg2 ? -qval : qval;
    end
  end

endmodule

// ===== rtl/interval_arithmetic_unit.sv =====
// Interval arithmetic unit, top level: input stage, add/lattice stage, two
// reciprocal pipelines, four bound multipliers, min/max and output register.
// Takes one item per cycle while a held result does not stall the pipeline.
// The reciprocal pipeline, one quotient bit per stage, sets the depth.
// Synchronous active-high reset empties all valid bits; data is not cleared.
module interval_arithmetic_unit import iau_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  value_t     a_lo,
  input  value_t     a_hi,
  input  logic       a_def,
  input  value_t     b_lo,
  input  value_t     b_hi,
  input  logic       b_def,
  output logic       out_valid,
  input  logic       out_stall,
  output value_t     res_lo,
  output value_t     res_hi,
  output logic       res_def,
  output logic [1:0] status,
  output logic       a_below_b,
  output logic       a_above_b,
  output logic       bounds_equal
);

  localparam int MS = RECIP_DEPTH;     // multiplier operand stage
  localparam int PS = RECIP_DEPTH + 4; // min/max pair stage

  logic   adv;
  item_t  in_item, early;
  item_t  ctl [0:CTL_DEPTH-1];
  logic   vld [0:CTL_DEPTH-1];
  value_t r_of_bh, r_of_bl, ylo, yhi;
  value_t p [0:3];
  value_t mn01, mx01, mn23, mx23, mn, mx;
  logic   use_mul;

  // whole pipeline moves unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    in_item       = '0;
    in_item.cmd   = command;
    in_item.a_lo  = a_lo;
    in_item.a_hi  = a_hi;
    in_item.a_def = a_def;
    in_item.b_lo  = b_lo;
    in_item.b_hi  = b_hi;
    in_item.b_def = b_def;
  end

  iau_addlat u_addlat (
    .item_in  (ctl[0]),
    .item_out (early)
  );

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CTL_DEPTH; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < CTL_DEPTH; k++) vld[k] <= vld[k-1];
      out_valid <= vld[CTL_DEPTH-1];
    end
  end

  // advance the control line
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= in_item;
      ctl[1] <= early;
      for (int k = 2; k < CTL_DEPTH; k++) ctl[k] <= ctl[k-1];
    end
  end

  iau_recip u_recip_hi (.clk(clk), .adv(adv), .value(ctl[0].b_hi), .recip(r_of_bh));
  iau_recip u_recip_lo (.clk(clk), .adv(adv), .value(ctl[0].b_lo), .recip(r_of_bl));

  // divide multiplies by the reciprocal interval
  assign ylo = (ctl[MS].cmd == CMD_DIV) ? r_of_bh : ctl[MS].b_lo;
  assign yhi = (ctl[MS].cmd == CMD_DIV) ? r_of_bl : ctl[MS].b_hi;

  iau_mul u_mul0 (.clk(clk), .adv(adv), .x(ctl[MS].a_lo), .y(ylo), .prod(p[0]));
  iau_mul u_mul1 (.clk(clk), .adv(adv), .x(ctl[MS].a_lo), .y(yhi), .prod(p[1]));
  iau_mul u_mul2 (.clk(clk), .adv(adv), .x(ctl[MS].a_hi), .y(ylo), .prod(p[2]));
  iau_mul u_mul3 (.clk(clk), .adv(adv), .x(ctl[MS].a_hi), .y(yhi), .prod(p[3]));

  // pairwise min and max of the products
  always_ff @(posedge clk) begin
    if (adv) begin
      mn01 <= (p[1] < p[0]) ? p[1] : p[0];
      mx01 <= (p[1] > p[0]) ? p[1] : p[0];
      mn23 <= (p[3] < p[2]) ? p[3] : p[2];
      mx23 <= (p[3] > p[2]) ? p[3] : p[2];
    end
  end

  assign mn      = (mn23 < mn01) ? mn23 : mn01;
  assign mx      = (mx23 > mx01) ? mx23 : mx01;
  assign use_mul = (ctl[PS].cmd == CMD_MUL || ctl[PS].cmd == CMD_DIV) &&
                   ctl[PS].e_st == ST_OK;

  // select the result and hold it until transfer
  always_ff @(posedge clk) begin
    if (adv) begin
      res_lo       <= use_mul ? mn : ctl[PS].e_lo;
      res_hi       <= use_mul ? mx : ctl[PS].e_hi;
      res_def      <= use_mul ? 1'b1 : ctl[PS].e_def;
      status       <= ctl[PS].e_st;
      a_below_b    <= ctl[PS].below;
      a_above_b    <= ctl[PS].above;
      bounds_equal <= ctl[PS].equal;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for interval_arithmetic_unit: random and directed interval commands,
// a scoreboard fed by a built-in predictor. Depends on iau_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top;
  import iau_pkg::*;

  localparam int LATENCY   = 2 * FRAC_BITS + 9;
  localparam int N_RANDOM  = 1950;
  localparam int WDOG_MAX  = 4000;

  typedef struct {
    logic [2:0] cmd;
    value_t     al, ah, bl, bh;
    logic       ad, bd;
  } op_t;

  typedef struct {
    value_t     lo, hi;
    logic       def;
    logic [1:0] st;
    logic       below, above, equal;
  } res_t;

  logic       clk, rst;
  logic       in_valid, in_stall, out_valid, out_stall;
  logic [2:0] command;
  value_t     a_lo, a_hi, b_lo, b_hi, res_lo, res_hi;
  logic       a_def, b_def, res_def, a_below_b, a_above_b, bounds_equal;
  logic [1:0] status;

  op_t  pending_ops[$];
  res_t expected_res[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_wait = 0, recv_wait = 0;
  bit   stim_done = 0;

  interval_arithmetic_unit u_top (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Predictor helpers on 64-bit signed values
  function automatic logic signed [63:0] sat_val(bit neg, logic [127:0] mag);
    if (mag >= {80'd0, MAXMAG}) return neg ? 64'(NINF) : 64'(PINF);
    return neg ? -$signed({1'b0, mag[62:0]}) : $signed({1'b0, mag[62:0]});
  endfunction

  function automatic logic signed [63:0] neg_bound(logic signed [63:0] v);
    if (v == NINF) return PINF;
    if (v == PINF) return NINF;
    return sat_val(v > 0, v < 0 ? -v : v);
  endfunction

  function automatic bit add_bound(logic signed [63:0] x, logic signed [63:0] y,
                                   output logic signed [63:0] r);
    logic signed [63:0] s;
    if ((x == NINF && y == PINF) || (x == PINF && y == NINF)) return 0;
    if (x == PINF || y == PINF) begin r = PINF; return 1; end
    if (x == NINF || y == NINF) begin r = NINF; return 1; end
    s = x + y;
    if (s >= PINF) s = PINF;
    if (s <= NINF) s = NINF;
    r = s;
    return 1;
  endfunction

  function automatic logic signed [63:0] mul_bound(logic signed [63:0] x,
                                                   logic signed [63:0] y);
    bit neg;
    logic [127:0] p;
    if (x == 0 || y == 0) return 0;
    neg = (x < 0) != (y < 0);
    if (x == NINF || x == PINF || y == NINF || y == PINF) return neg ? NINF : PINF;
    p = 128'(x < 0 ? -x : x) * 128'(y < 0 ? -y : y);
    return sat_val(neg, p >> FRAC_BITS);
  endfunction

  function automatic logic signed [63:0] recip_bound(logic signed [63:0] v);
    logic [127:0] q;
    if (v == NINF || v == PINF) return 0;
    if (v == 0) return PINF;
    q = (128'd1 << (2 * FRAC_BITS)) / 128'(v < 0 ? -v : v);
    return sat_val(v < 0, q);
  endfunction

  function automatic void mul_interval(logic signed [63:0] al, logic signed [63:0] ah,
                                       logic signed [63:0] bl, logic signed [63:0] bh,
                                       output logic signed [63:0] lo,
                                       output logic signed [63:0] hi);
    logic signed [63:0] p[4];
    p[0] = mul_bound(al, bl); p[1] = mul_bound(al, bh);
    p[2] = mul_bound(ah, bl); p[3] = mul_bound(ah, bh);
    lo = p[0]; hi = p[0];
    for (int i = 1; i < 4; i++) begin
      if (p[i] < lo) lo = p[i];
      if (p[i] > hi) hi = p[i];
    end
  endfunction

  function automatic res_t predict_interval(op_t o);
    res_t r;
    logic signed [63:0] al, ah, bl, bh, rl, rh, tl, th, t;
    logic [1:0] st;
    bit rd;
    al = o.al; ah = o.ah; bl = o.bl; bh = o.bh;
    rl = 0; rh = 0; rd = 1; st = ST_OK;
    if (o.cmd <= CMD_DIV) begin
      if (!o.ad || !o.bd) st = ST_UNDEF;
      else if (o.cmd == CMD_ADD || o.cmd == CMD_SUB) begin
        if (o.cmd == CMD_SUB) begin
          tl = neg_bound(bh); th = neg_bound(bl);
          if (th < tl) begin t = tl; tl = th; th = t; end
        end else begin
          tl = bl; th = bh;
        end
        if (!add_bound(al, tl, rl) || !add_bound(ah, th, rh)) st = ST_UNDEF;
      end else if (o.cmd == CMD_MUL) mul_interval(al, ah, bl, bh, rl, rh);
      else if (bl > 0 || bh < 0)
        mul_interval(al, ah, recip_bound(bh), recip_bound(bl), rl, rh);
      else st = ST_ZSPAN;
    end else if (!o.bd) begin
      rl = al; rh = ah; rd = o.ad;
      if (!o.ad) st = ST_UNDEF;
    end else if (!o.ad) begin
      rl = bl; rh = bh;
    end else if (o.cmd == CMD_HULL) begin
      rl = al < bl ? al : bl; rh = ah > bh ? ah : bh;
      if (rl > rh) st = ST_EMPTY;
    end else if (o.cmd == CMD_ISECT) begin
      rl = al > bl ? al : bl; rh = ah < bh ? ah : bh;
      if (rl > rh) st = ST_EMPTY;
    end else if (o.cmd == CMD_WIDEN) begin
      rl = bl < al ? 64'(NINF) : al; rh = bh > ah ? 64'(PINF) : ah;
    end else begin
      rl = (al == NINF) ? bl : (al < bl ? al : bl);
      rh = (ah == PINF) ? bh : (ah > bh ? ah : bh);
    end
    if (st == ST_EMPTY || st == ST_ZSPAN || (st == ST_UNDEF && o.cmd <= CMD_DIV)) begin
      rl = 0; rh = 0; rd = 0;
    end
    if (st == ST_UNDEF && o.cmd > CMD_DIV) rd = 0;
    r.lo = rl[VALUE_WIDTH-1:0]; r.hi = rh[VALUE_WIDTH-1:0];
    r.def = rd; r.st = st;
    r.below = ah < bl; r.above = bh < al; r.equal = (al == bl && ah == bh);
    return r;
  endfunction

  // Random bound: mix of extremes, small values, and full-width noise
  function automatic value_t rand_bound();
    case ($urandom_range(0, 9))
      0: return NINF;
      1: return PINF;
      2: return value_t'($signed($urandom_range(0, 8)) - 4);
      3, 4: return value_t'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      5: return value_t'(64'sd65536 * ($signed($urandom_range(0, 200)) - 100));
      6: return NINF + value_t'($urandom_range(0, 2));
      default: return value_t'({$urandom, $urandom});
    endcase
  endfunction

  function automatic op_t make_op(logic [2:0] c, value_t al, value_t ah, logic ad,
                                  value_t bl, value_t bh, logic bd);
    op_t o;
    o.cmd = c; o.al = al; o.ah = ah; o.ad = ad; o.bl = bl; o.bh = bh; o.bd = bd;
    return o;
  endfunction

  // Fill the queue of pending transfers
  initial begin
    op_t o;
    value_t x, y;
    for (int c = 0; c < 8; c++)
      pending_ops.push_back(make_op(3'(c), -value_t'(65536), value_t'(131072), 1,
                                    value_t'(65536), value_t'(196608), 1));
    pending_ops.push_back(make_op(CMD_ADD, NINF, ZERO, 1, ZERO, PINF, 1));
    pending_ops.push_back(make_op(CMD_SUB, NINF, PINF, 1, NINF, PINF, 1));
    pending_ops.push_back(make_op(CMD_SUB, ZERO, ZERO, 1, NINF + 1, ZERO, 1));
    pending_ops.push_back(make_op(CMD_MUL, ZERO, PINF, 1, NINF, PINF, 1));
    pending_ops.push_back(make_op(CMD_MUL, PINF - 1, PINF - 1, 1, PINF - 1, NINF + 1, 1));
    pending_ops.push_back(make_op(CMD_DIV, value_t'(65536), value_t'(65536), 1,
                                  -value_t'(1), value_t'(1), 1));
    pending_ops.push_back(make_op(CMD_DIV, value_t'(65536), PINF, 1, value_t'(1), PINF, 1));
    pending_ops.push_back(make_op(CMD_DIV, NINF, PINF, 0, value_t'(3), ZERO, 1));
    pending_ops.push_back(make_op(CMD_HULL, value_t'(5), value_t'(1), 1,
                                  value_t'(7), value_t'(2), 1));
    pending_ops.push_back(make_op(CMD_ISECT, ZERO, value_t'(1), 1, value_t'(5), value_t'(9), 1));
    pending_ops.push_back(make_op(CMD_WIDEN, value_t'(5), value_t'(9), 0, value_t'(1), PINF, 1));
    pending_ops.push_back(make_op(CMD_NARROW, NINF, PINF, 1, value_t'(3), value_t'(4), 1));
    pending_ops.push_back(make_op(CMD_NARROW, NINF, PINF, 0, value_t'(3), value_t'(4), 0));
    pending_ops.push_back(make_op(CMD_HULL, value_t'(5), value_t'(9), 1, NINF, PINF, 0));
    for (int i = 0; i < N_RANDOM; i++) begin
      o.cmd = 3'($urandom_range(0, 7));
      x = rand_bound(); y = rand_bound();
      // mostly well-ordered intervals, some inverted
      if ($urandom_range(0, 9) != 0 && x > y) begin o.al = y; o.ah = x; end
      else begin o.al = x; o.ah = y; end
      x = rand_bound(); y = rand_bound();
      if ($urandom_range(0, 9) != 0 && x > y) begin o.bl = y; o.bh = x; end
      else begin o.bl = x; o.bh = y; end
      if ($urandom_range(0, 7) == 0) o.bl = o.al;
      if ($urandom_range(0, 7) == 0) o.bh = o.ah;
      o.ad = $urandom_range(0, 9) != 0;
      o.bd = $urandom_range(0, 9) != 0;
      pending_ops.push_back(o);
    end
  end

  // Reset once, then release
  initial begin
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  // Driver: pull one op per transfer, wait a random gap between transfers
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0; command <= '0; a_lo <= '0; a_hi <= '0; a_def <= 0;
      b_lo <= '0; b_hi <= '0; b_def <= 0;
      send_wait <= 0;
    end else if (in_valid && in_stall) begin
      // hold the stalled payload
    end else begin
      op_t o;
      if (in_valid) begin
        o = pending_ops.pop_front();
        expected_res.push_back(predict_interval(o));
      end
      if (send_wait > 0) begin
        in_valid <= 0;
        send_wait <= send_wait - 1;
      end else if (pending_ops.size() > 0) begin
        o = pending_ops[0];
        in_valid <= 1;
        command <= o.cmd; a_lo <= o.al; a_hi <= o.ah; a_def <= o.ad;
        b_lo <= o.bl; b_hi <= o.bh; b_def <= o.bd;
        send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 0;
        stim_done <= 1;
      end
    end
  end

  // Monitor: compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      recv_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        res_t e;
        if (expected_res.size() == 0) begin
          $display("%0t unexpected result lo=%h hi=%h", $time, res_lo, res_hi);
          errors++;
        end else begin
          e = expected_res.pop_front();
          if ({res_lo, res_hi, res_def, status, a_below_b, a_above_b, bounds_equal} !==
              {e.lo, e.hi, e.def, e.st, e.below, e.above, e.equal}) begin
            $display("%0t mismatch exp lo=%h hi=%h def=%b st=%0d flags=%b%b%b",
                     $time, e.lo, e.hi, e.def, e.st, e.below, e.above, e.equal);
            $display("%0t          got lo=%h hi=%h def=%b st=%0d flags=%b%b%b",
                     $time, res_lo, res_hi, res_def, status, a_below_b, a_above_b,
                     bounds_equal);
            errors++;
          end
        end
      end
      // stall a random number of cycles, with stall-free stretches
      if (recv_wait > 0) begin
        out_stall <= 1;
        recv_wait <= recv_wait - 1;
      end else begin
        out_stall <= 0;
        recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(negedge rst);
    while (!(stim_done && expected_res.size() == 0) && idle_cycles < WDOG_MAX)
      @(posedge clk);
    if (idle_cycles >= WDOG_MAX) begin
      $display("CHECK FAILED");
    end else begin
      repeat (LATENCY + 20) @(posedge clk);
      if (errors == 0 && expected_res.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/iau_pkg.sv
rtl/iau_addlat.sv
rtl/iau_recip.sv
rtl/iau_mul.sv
rtl/interval_arithmetic_unit.sv
tb/sv/tb_top.sv
